// ===== hw/rtl/lpc_pkg.sv =====
// ----------------------------------------------------------------------------
// lpc_pkg: shared types and constants of the length prefix codec
// Holds the operation, result kind and error codes, the thresholds and
// prefix bytes of the code, and the encode function.
// ----------------------------------------------------------------------------
`default_nettype none

package lpc_pkg;

	// operation of an input item
	localparam logic OP_ENCODE = 1'b0;
	localparam logic OP_DECODE = 1'b1;

	// kind of a result item
	localparam logic KIND_BYTE    = 1'b0;
	localparam logic KIND_OUTCOME = 1'b1;

	// decode outcome codes
	localparam logic [1:0] ERR_OK    = 2'd0;
	localparam logic [1:0] ERR_TRUNC = 2'd1;
	localparam logic [1:0] ERR_LIMIT = 2'd2;

	// code thresholds and prefix bytes
	localparam logic [31:0] SHORT_LIMIT    = 32'd240;
	localparam logic [31:0] TWO_BYTE_LIMIT = 32'd13 << 8;
	localparam logic [7:0]  SHORT_MAX_BYTE = 8'd240;
	localparam logic [7:0]  TWO_BYTE_MAX   = 8'd252;
	localparam logic [7:0]  PREFIX_TWO     = 8'hF0;
	localparam logic [7:0]  PREFIX_16      = 8'd253;
	localparam logic [7:0]  PREFIX_24      = 8'd254;
	localparam logic [7:0]  PREFIX_32      = 8'd255;
	localparam logic [3:0]  NIBBLE_MASK    = 4'hF;
	localparam logic [2:0]  LONG_BIAS      = 3'd3;
	localparam logic [31:0] LIMIT_RESET    = 32'd64 << 20;

	// encoded bytes, first byte in the top lane
	typedef struct packed {
		logic [2:0]  cnt;
		logic [39:0] bytes;
	} enc_t;

	// outcome of one decode step
	typedef struct packed {
		logic        has_result;
		logic [31:0] length;
		logic [1:0]  err;
	} dec_out_t;

	function automatic enc_t encode_length(input logic [31:0] len);
		enc_t r;
		if (len < SHORT_LIMIT) begin
			r.cnt   = 3'd1;
			r.bytes = {len[7:0], 32'h0};
		end else if (len < TWO_BYTE_LIMIT) begin
			r.cnt   = 3'd2;
			r.bytes = {PREFIX_TWO | {4'h0, len[11:8]}, len[7:0], 24'h0};
		end else if (len[31:16] == 16'h0) begin
			r.cnt   = 3'd3;
			r.bytes = {PREFIX_16, len[15:0], 16'h0};
		end else if (len[31:24] == 8'h0) begin
			r.cnt   = 3'd4;
			r.bytes = {PREFIX_24, len[23:0], 8'h0};
		end else begin
			r.cnt   = 3'd5;
			r.bytes = {PREFIX_32, len};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lpc_in_if.sv =====
// ----------------------------------------------------------------------------
// lpc_in_if: input channel of the length prefix codec
// Valid/ready channel carrying one encode or decode item.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpc_in_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [31:0] length_in;
	logic [7:0]  byte_in;
	logic        buffer_end;

	modport source (output valid, output op, output length_in, output byte_in,
		output buffer_end, input ready);
	modport sink (input valid, input op, input length_in, input byte_in,
		input buffer_end, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lpc_out_if.sv =====
// ----------------------------------------------------------------------------
// lpc_out_if: result channel of the length prefix codec
// Valid/ready channel carrying one encoded byte or one decode outcome.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpc_out_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  byte_out;
	logic        last_byte;
	logic [31:0] length_out;
	logic [1:0]  error_code;

	modport source (output valid, output kind, output byte_out, output last_byte,
		output length_out, output error_code, input ready);
	modport sink (input valid, input kind, input byte_out, input last_byte,
		input length_out, input error_code, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/length_prefix_codec.sv =====
// ----------------------------------------------------------------------------
// length_prefix_codec: prefix-byte length encoder and decoder
// Top level with input register, decode core, encoder and result burst.
// ----------------------------------------------------------------------------
// An item is taken into an input register and then, once the result register
// is free, turned into its results there. Decode items give at most one
// outcome and run at one item per cycle while the result port is not stalled.
// An encode item holds the result register until each of its 1 to 5 encoded
// bytes has been taken, and the next item waits in the input register
// meanwhile; the sustained rate is set by the number of bytes leaving the
// result port. The user must write the limit register through cfg_we/cfg_wdata
// only while the block is idle; the block itself does not enforce this.
`default_nettype none

module length_prefix_codec (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata,
	lpc_in_if.sink           cmd,
	lpc_out_if.source        rsp
);

	logic [31:0] limit_q;

	logic        valid_s1;
	logic        op_s1;
	logic [31:0] len_s1;
	logic [7:0]  byte_s1;
	logic        end_s1;

	logic        out_valid_q;
	logic        out_kind_q;
	logic [39:0] out_shift_q;
	logic [2:0]  out_cnt_q;
	logic [31:0] out_len_q;
	logic [1:0]  out_err_q;

	logic                 out_pop;
	logic                 burst_free;
	logic                 s1_move;
	logic                 dec_step;
	lpc_pkg::enc_t        enc;
	lpc_pkg::dec_out_t    dec;

	// limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= lpc_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	// handshake and stage movement
	assign out_pop    = out_valid_q && rsp.ready;
	assign burst_free = !out_valid_q || (out_pop && (out_cnt_q == 3'd1));
	assign s1_move    = valid_s1 && burst_free;
	assign cmd.ready  = !valid_s1 || s1_move;
	assign dec_step   = s1_move && (op_s1 == lpc_pkg::OP_DECODE);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			op_s1   <= cmd.op;
			len_s1  <= cmd.length_in;
			byte_s1 <= cmd.byte_in;
			end_s1  <= cmd.buffer_end;
		end
	end

	// decode state and outcome
	lpc_dec_core u_dec (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (dec_step),
		.byte_in    (byte_s1),
		.buffer_end (end_s1),
		.limit      (limit_q),
		.outcome    (dec)
	);

	// encoded bytes of the held length
	assign enc = lpc_pkg::encode_length(len_s1);

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= (op_s1 == lpc_pkg::OP_ENCODE) || dec.has_result;
		end else if (burst_free) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload and byte shifter
	always_ff @(posedge clk) begin
		if (s1_move) begin
			if (op_s1 == lpc_pkg::OP_ENCODE) begin
				out_kind_q  <= lpc_pkg::KIND_BYTE;
				out_shift_q <= enc.bytes;
				out_cnt_q   <= enc.cnt;
				out_len_q   <= '0;
				out_err_q   <= lpc_pkg::ERR_OK;
			end else begin
				out_kind_q  <= lpc_pkg::KIND_OUTCOME;
				out_shift_q <= '0;
				out_cnt_q   <= 3'd1;
				out_len_q   <= dec.length;
				out_err_q   <= dec.err;
			end
		end else if (out_pop) begin
			out_shift_q <= {out_shift_q[31:0], 8'h0};
			out_cnt_q   <= out_cnt_q - 3'd1;
		end
	end

	// result port
	assign rsp.valid      = out_valid_q;
	assign rsp.kind       = out_kind_q;
	assign rsp.byte_out   = out_shift_q[39:32];
	assign rsp.last_byte  = (out_kind_q == lpc_pkg::KIND_BYTE) && (out_cnt_q == 3'd1);
	assign rsp.length_out = out_len_q;
	assign rsp.error_code = out_err_q;

endmodule

`default_nettype wire

// ===== hw/rtl/lpc_dec_core.sv =====
// ----------------------------------------------------------------------------
// lpc_dec_core: decode state of the length prefix codec
// Holds the bytes still awaited, the partial value and the long form flag,
// and gives the outcome of the current byte in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lpc_dec_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic [7:0]        byte_in,
	input  wire logic              buffer_end,
	input  wire logic [31:0]       limit,
	output lpc_pkg::dec_out_t      outcome
);

	logic [2:0]  pend_q;
	logic [31:0] pv_q;
	logic        lf_q;

	logic [2:0]  pend_n;
	logic [31:0] pv_n;
	logic        lf_n;
	logic [31:0] shifted;
	logic [2:0]  pend_dec;

	// next decode state and outcome for the current byte
	always_comb begin
		pend_n   = pend_q;
		pv_n     = pv_q;
		lf_n     = lf_q;
		shifted  = {pv_q[23:0], byte_in};
		pend_dec = pend_q - 3'd1;
		outcome  = '0;
		if (pend_q == 3'd0) begin
			if (byte_in < lpc_pkg::SHORT_MAX_BYTE) begin
				outcome.has_result = 1'b1;
				outcome.length     = {24'h0, byte_in};
				outcome.err        = lpc_pkg::ERR_OK;
			end else begin
				if (byte_in <= lpc_pkg::TWO_BYTE_MAX) begin
					pv_n   = {28'h0, byte_in[3:0] & lpc_pkg::NIBBLE_MASK};
					pend_n = 3'd1;
				end else begin
					pv_n   = '0;
					pend_n = byte_in[2:0] - lpc_pkg::LONG_BIAS;
				end
				lf_n = (byte_in == lpc_pkg::PREFIX_32);
				if (buffer_end) begin
					pend_n             = '0;
					pv_n               = '0;
					lf_n               = 1'b0;
					outcome.has_result = 1'b1;
					outcome.err        = lpc_pkg::ERR_TRUNC;
				end
			end
		end else if (pend_dec == 3'd0) begin
			// code complete
			pend_n             = '0;
			pv_n               = '0;
			lf_n               = 1'b0;
			outcome.has_result = 1'b1;
			if (lf_q && (shifted > limit)) begin
				outcome.err = lpc_pkg::ERR_LIMIT;
			end else begin
				outcome.length = shifted;
				outcome.err    = lpc_pkg::ERR_OK;
			end
		end else begin
			pv_n   = shifted;
			pend_n = pend_dec;
			if (buffer_end) begin
				pend_n             = '0;
				pv_n               = '0;
				lf_n               = 1'b0;
				outcome.has_result = 1'b1;
				outcome.err        = lpc_pkg::ERR_TRUNC;
			end
		end
	end

	// decode state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			pv_q   <= '0;
			lf_q   <= 1'b0;
		end else if (step) begin
			pend_q <= pend_n;
			pv_q   <= pv_n;
			lf_q   <= lf_n;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/lpc_checker.sv =====
// ----------------------------------------------------------------------------
// lpc_checker: port checks of the length prefix codec
// Watches the result port over time and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lpc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic        rsp_kind,
	input wire logic [7:0]  rsp_byte_out,
	input wire logic        rsp_last_byte,
	input wire logic [31:0] rsp_length_out,
	input wire logic [1:0]  rsp_error_code
);

	// stalled result holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
		&& $stable(rsp_byte_out) && $stable(rsp_last_byte)
		&& $stable(rsp_length_out) && $stable(rsp_error_code))
		else $error("result changed while stalled");

	// an encoding continues without a gap until its last byte
	a_enc_burst: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready && (rsp_kind == lpc_pkg::KIND_BYTE) && !rsp_last_byte
		|=> rsp_valid && (rsp_kind == lpc_pkg::KIND_BYTE))
		else $error("encoded item cut short");

	// encoded bytes carry no length and no error
	a_enc_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_kind == lpc_pkg::KIND_BYTE)
		|-> (rsp_length_out == 32'h0) && (rsp_error_code == lpc_pkg::ERR_OK))
		else $error("encoded byte with decode fields");

	// decode outcomes carry no byte, and errors carry no length
	a_dec_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_kind == lpc_pkg::KIND_OUTCOME)
		|-> (rsp_byte_out == 8'h0) && !rsp_last_byte
		&& ((rsp_error_code == lpc_pkg::ERR_OK) || (rsp_length_out == 32'h0)))
		else $error("bad decode outcome fields");

	// only defined error codes appear
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_error_code == lpc_pkg::ERR_OK)
		|| (rsp_error_code == lpc_pkg::ERR_TRUNC) || (rsp_error_code == lpc_pkg::ERR_LIMIT))
		else $error("undefined error code");

endmodule

bind length_prefix_codec lpc_checker u_lpc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_kind       (rsp.kind),
	.rsp_byte_out   (rsp.byte_out),
	.rsp_last_byte  (rsp.last_byte),
	.rsp_length_out (rsp.length_out),
	.rsp_error_code (rsp.error_code)
);

`default_nettype wire

// ===== dv/lpc_result_checker.sv =====
// ----------------------------------------------------------------------------
// lpc_result_checker: result prediction and comparison for the length codec
// Watches both channels and the limit register port. Every accepted item runs
// through a local encoder and decoder model; the results it predicts are
// queued and compared field by field with the results the block emits.
// ----------------------------------------------------------------------------
`default_nettype none

module lpc_result_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata,
	lpc_in_if                cmd,
	lpc_out_if               rsp,
	output int               mismatches,
	output int               pending_results
);

	typedef struct packed {
		logic        kind;
		logic [7:0]  byte_out;
		logic        last_byte;
		logic [31:0] length_out;
		logic [1:0]  error_code;
	} result_t;

	result_t     expected_results[$];
	result_t     want;
	int          result_count;

	// local copy of the limit register and the decoder state
	logic [31:0] long_form_max;
	logic [2:0]  bytes_left;
	logic [31:0] value_acc;
	logic        in_long_form;

	task automatic report(input string msg);
		$display("%0t: result %0d: %s", $time, result_count, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
		input logic [31:0] exp_val);
		if (got !== exp_val)
			report($sformatf("%s is %0h, expected %0h", name, got, exp_val));
	endtask

	function automatic result_t outcome(input logic [31:0] len, input logic [1:0] err);
		return '{lpc_pkg::KIND_OUTCOME, 8'h00, 1'b0, len, err};
	endfunction

	// prefix byte first, then the low bytes of the length, most significant first
	task automatic predict_encode(input logic [31:0] len);
		logic [7:0] lead;
		int         n;
		if (len < lpc_pkg::SHORT_LIMIT) begin
			n    = 1;
			lead = len[7:0];
		end else if (len < lpc_pkg::TWO_BYTE_LIMIT) begin
			n    = 2;
			lead = lpc_pkg::PREFIX_TWO | {4'h0, len[11:8]};
		end else if (len <= 32'h0000_FFFF) begin
			n    = 3;
			lead = lpc_pkg::PREFIX_16;
		end else if (len <= 32'h00FF_FFFF) begin
			n    = 4;
			lead = lpc_pkg::PREFIX_24;
		end else begin
			n    = 5;
			lead = lpc_pkg::PREFIX_32;
		end
		expected_results.push_back('{lpc_pkg::KIND_BYTE, lead, n == 1, 32'h0,
			lpc_pkg::ERR_OK});
		for (int i = 1; i < n; i++)
			expected_results.push_back('{lpc_pkg::KIND_BYTE,
				8'(len >> (8 * (n - 1 - i))), i == n - 1, 32'h0, lpc_pkg::ERR_OK});
	endtask

	task automatic go_idle();
		bytes_left   = 3'd0;
		value_acc    = 32'h0;
		in_long_form = 1'b0;
	endtask

	// one coded byte: start a code, extend it, or finish it
	task automatic predict_decode(input logic [7:0] b, input logic at_end);
		logic over;
		if (bytes_left == 3'd0) begin
			if (b < lpc_pkg::SHORT_MAX_BYTE) begin
				expected_results.push_back(outcome({24'h0, b}, lpc_pkg::ERR_OK));
				return;
			end
			if (b <= lpc_pkg::TWO_BYTE_MAX) begin
				value_acc  = {28'h0, b[3:0]};
				bytes_left = 3'd1;
			end else begin
				value_acc  = 32'h0;
				bytes_left = b[2:0] - lpc_pkg::LONG_BIAS;
			end
			in_long_form = (b == lpc_pkg::PREFIX_32);
		end else begin
			value_acc  = {value_acc[23:0], b};
			bytes_left = bytes_left - 3'd1;
			if (bytes_left == 3'd0) begin
				over = in_long_form && (value_acc > long_form_max);
				expected_results.push_back(over ? outcome(32'h0, lpc_pkg::ERR_LIMIT)
					: outcome(value_acc, lpc_pkg::ERR_OK));
				go_idle();
				return;
			end
		end
		// buffer ran out with bytes still awaited
		if (at_end) begin
			go_idle();
			expected_results.push_back(outcome(32'h0, lpc_pkg::ERR_TRUNC));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_form_max = lpc_pkg::LIMIT_RESET;
			go_idle();
			expected_results.delete();
			result_count    = 0;
			mismatches      = 0;
			pending_results = 0;
		end else begin
			// compare an emitted result with the oldest prediction
			if (rsp.valid && rsp.ready) begin
				result_count++;
				if (expected_results.size() == 0) begin
					report("result with nothing expected");
				end else begin
					want = expected_results.pop_front();
					check_field("kind", 32'(rsp.kind), 32'(want.kind));
					check_field("byte_out", 32'(rsp.byte_out), 32'(want.byte_out));
					check_field("last_byte", 32'(rsp.last_byte), 32'(want.last_byte));
					check_field("length_out", rsp.length_out, want.length_out);
					check_field("error_code", 32'(rsp.error_code), 32'(want.error_code));
				end
			end
			// limit register write
			if (cfg_we)
				long_form_max = cfg_wdata;
			// predict the results of an accepted item
			if (cmd.valid && cmd.ready) begin
				if (cmd.op == lpc_pkg::OP_ENCODE)
					predict_encode(cmd.length_in);
				else
					predict_decode(cmd.byte_in, cmd.buffer_end);
			end
			pending_results = expected_results.size();
		end
	end

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the length prefix codec
// Drives encode lengths and coded byte streams, directed edge cases first and
// then random well-formed codes mixed with broken codes and noise, across
// several limit register settings, with random idling on both channels and
// one long result stall. Checking is done by lpc_result_checker.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

	localparam int HOLD_CYCLES    = 80;
	localparam int SETTLE_CYCLES  = 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int ITEM_TOTAL     = 320;

	// lengths on both sides of each form boundary
	localparam logic [31:0] EDGE_LENGTHS [10] = '{32'd0, 32'd239, 32'd240, 32'd3327,
		32'd3328, 32'h0000_FFFF, 32'h0001_0000, 32'h00FF_FFFF, 32'h0100_0000,
		32'hFFFF_FFFF};

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [31:0] cfg_wdata;
	logic        steady;
	logic        hold_req;
	logic [31:0] limit_now;
	int          items_sent;
	int          stall_count;
	int          mismatches;
	int          pending_results;

	lpc_in_if  cmd_ch();
	lpc_out_if rsp_ch();

	length_prefix_codec DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd_ch),
		.rsp       (rsp_ch)
	);

	lpc_result_checker u_result_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.cmd             (cmd_ch),
		.rsp             (rsp_ch),
		.mismatches      (mismatches),
		.pending_results (pending_results)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side: random stalls, a long hold-off on request
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				rsp_ch.ready <= steady || ($urandom_range(99) >= 35);
			end
		end
	end

	// watchdog on cycles with no item moving on either channel
	always @(posedge clk) begin
		if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			stall_count <= 0;
		end else begin
			stall_count <= stall_count + 1;
			if (stall_count == WATCHDOG_LIMIT) begin
				$display("length_prefix_codec test failed");
				$finish;
			end
		end
	end

	// offer one item, with an occasional gap before it, and wait for acceptance
	task automatic offer(input logic op, input logic [31:0] len, input logic [7:0] b,
		input logic at_end);
		if (!steady && $urandom_range(99) < 35) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(negedge clk);
		end
		cmd_ch.valid      <= 1'b1;
		cmd_ch.op         <= op;
		cmd_ch.length_in  <= len;
		cmd_ch.byte_in    <= b;
		cmd_ch.buffer_end <= at_end;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic offer_encode(input logic [31:0] len);
		offer(lpc_pkg::OP_ENCODE, len, 8'($urandom), 1'($urandom));
	endtask

	task automatic offer_decode(input logic [7:0] b, input logic at_end);
		offer(lpc_pkg::OP_DECODE, $urandom, b, at_end);
	endtask

	task automatic send_random_encode();
		logic [31:0] len;
		case ($urandom_range(5))
			0: len = $urandom_range(239);
			1: len = $urandom_range(3327, 240);
			2: len = $urandom_range(32'h0000_FFFF, 3328);
			3: len = $urandom_range(32'h00FF_FFFF, 32'h0001_0000);
			4: len = $urandom_range(32'hFFFF_FFFF, 32'h0100_0000);
			default: len = EDGE_LENGTHS[$urandom_range(9)];
		endcase
		offer_encode(len);
	endtask

	// a coded length with random content; sometimes cut short or interleaved
	task automatic send_coded_length();
		logic [31:0] val;
		logic [7:0]  lead;
		logic [7:0]  b;
		logic        at_end;
		int          tail;
		val = $urandom;
		case ($urandom_range(4))
			0: begin
				lead = 8'($urandom_range(239));
				tail = 0;
			end
			1: begin
				lead = 8'($urandom_range(252, 240));
				tail = 1;
			end
			2: begin
				lead = lpc_pkg::PREFIX_16;
				tail = 2;
			end
			3: begin
				lead = lpc_pkg::PREFIX_24;
				tail = 3;
			end
			default: begin
				lead = lpc_pkg::PREFIX_32;
				tail = 4;
				// values around the limit
				case ($urandom_range(4))
					0: val = limit_now;
					1: val = limit_now + 32'd1;
					2: val = limit_now - 32'd1;
					3: val = $urandom_range(32'h03FF_FFFF);
					default: ;
				endcase
			end
		endcase
		for (int k = 0; k <= tail; k++) begin
			if (k == 0) begin
				b = lead;
			end else begin
				b = 8'(val >> (8 * (tail - k)));
				if ($urandom_range(99) < 8)
					send_random_encode();
			end
			if (k == tail)
				at_end = ($urandom_range(99) < 25);
			else
				at_end = ($urandom_range(99) < 6);
			offer_decode(b, at_end);
			if (at_end && k != tail)
				break;
		end
	endtask

	task automatic run_random(input int target);
		int pick;
		while (items_sent < target) begin
			pick = $urandom_range(99);
			if (pick < 40)
				send_random_encode();
			else if (pick < 85)
				send_coded_length();
			else
				offer_decode(8'($urandom), 1'($urandom));
		end
	endtask

	// stop offering, wait for every expected result, then let the pipeline settle
	task automatic drain();
		cmd_ch.valid <= 1'b0;
		while (pending_results != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_limit(input logic [31:0] value);
		limit_now  = value;
		cfg_wdata <= value;
		cfg_we    <= 1'b1;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_wdata         = 32'h0;
		cmd_ch.valid      = 1'b0;
		cmd_ch.op         = lpc_pkg::OP_ENCODE;
		cmd_ch.length_in  = 32'h0;
		cmd_ch.byte_in    = 8'h00;
		cmd_ch.buffer_end = 1'b0;
		steady            = 1'b0;
		hold_req          = 1'b0;
		limit_now         = lpc_pkg::LIMIT_RESET;
		items_sent        = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// encode at each form boundary
		foreach (EDGE_LENGTHS[i])
			offer_encode(EDGE_LENGTHS[i]);
		// single-byte codes, one completing with buffer end set
		offer_decode(8'd0, 1'b1);
		offer_decode(8'd239, 1'b0);
		// two-byte code with an encode in the middle, completed at buffer end
		offer_decode(lpc_pkg::PREFIX_TWO, 1'b0);
		offer_encode(32'h0100_0000);
		offer_decode(8'h00, 1'b1);
		// five-byte code just above the reset limit
		offer_decode(lpc_pkg::PREFIX_32, 1'b0);
		offer_decode(8'h04, 1'b0);
		offer_decode(8'h00, 1'b0);
		offer_decode(8'h00, 1'b0);
		offer_decode(8'h01, 1'b0);
		// buffer ends right after a prefix
		offer_decode(lpc_pkg::PREFIX_16, 1'b1);
		// four-byte code
		offer_decode(lpc_pkg::PREFIX_24, 1'b0);
		offer_decode(8'h12, 1'b0);
		offer_decode(8'h34, 1'b0);
		offer_decode(8'h56, 1'b0);
		// largest two-byte prefix
		offer_decode(lpc_pkg::TWO_BYTE_MAX, 1'b0);
		offer_decode(8'hFF, 1'b0);

		run_random(110);

		drain();
		write_limit(32'h0);
		run_random(160);

		// no idling on either side
		drain();
		write_limit(32'hFFFF_FFFF);
		steady = 1'b1;
		run_random(210);
		steady = 1'b0;

		// long result stall while items keep coming
		drain();
		write_limit($urandom);
		hold_req = 1'b1;
		run_random(270);

		drain();
		write_limit(lpc_pkg::LIMIT_RESET);
		run_random(ITEM_TOTAL);

		drain();
		if (mismatches == 0)
			$display("length_prefix_codec test passed");
		else
			$display("length_prefix_codec test failed");
		$finish;
	end

endmodule

`default_nettype wire
